// ===== hdl/vnorm_pkg.sv =====
// Shared types and constants for the four-component vector normalizer.
// Used by every module of the block; depends on nothing else.
`default_nettype none
package vnorm_pkg;

  localparam int COMP_WIDTH    = 16;
  localparam int OUT_FRAC_BITS = 14;
  localparam int UNIT_WIDTH    = OUT_FRAC_BITS + 2;
  localparam int LEN_WIDTH     = COMP_WIDTH + 1;
  localparam int SQ_WIDTH      = 2 * COMP_WIDTH;
  localparam int SUM_WIDTH     = 2 * COMP_WIDTH + 1;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_AW      = 2;
  localparam int LEVEL_WIDTH   = QUEUE_AW + 1;
  localparam int NUM_COMP      = 4;

  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] comp_x;
    logic signed [COMP_WIDTH-1:0] comp_y;
    logic signed [COMP_WIDTH-1:0] comp_z;
    logic signed [COMP_WIDTH-1:0] comp_w;
  } vec_in_t;

  typedef struct packed {
    logic signed [UNIT_WIDTH-1:0] unit_x;
    logic signed [UNIT_WIDTH-1:0] unit_y;
    logic signed [UNIT_WIDTH-1:0] unit_z;
    logic signed [UNIT_WIDTH-1:0] unit_w;
    logic [LEN_WIDTH-1:0]         vec_length;
    logic                         is_zero;
  } vec_out_t;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic [NUM_COMP-1:0][COMP_WIDTH-1:0] mag;
    logic [NUM_COMP-1:0]                 neg;
    logic [SUM_WIDTH-1:0]                sum_sq;
  } work_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic [LEVEL_WIDTH-1:0] level;
    logic                   not_empty;
  } queue_status_t;

endpackage
`default_nettype wire

// ===== hdl/vnorm_front.sv =====
// Front part: accepts vectors, splits sign and magnitude, squares and sums.
// Depends on vnorm_pkg.
`default_nettype none
module vnorm_front (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire vnorm_pkg::vec_in_t      in_item,
  input  wire vnorm_pkg::queue_status_t qstat,
  output logic                         push,
  output vnorm_pkg::work_t             push_item
);
  import vnorm_pkg::*;

  logic                                a_valid;
  logic [NUM_COMP-1:0][COMP_WIDTH-1:0] a_mag;
  logic [NUM_COMP-1:0]                 a_neg;
  logic [NUM_COMP-1:0][SQ_WIDTH-1:0]   a_sq;
  logic [NUM_COMP-1:0][COMP_WIDTH-1:0] comp;
  logic [NUM_COMP-1:0][COMP_WIDTH-1:0] mag_next;
  logic [LEVEL_WIDTH:0]                credit_used;
  logic                                take;

  // Entries already queued plus those still in flight must leave room.
  assign credit_used = {1'b0, qstat.level} + (LEVEL_WIDTH+1)'(a_valid)
                       + (LEVEL_WIDTH+1)'(push);
  assign in_stall    = credit_used >= (LEVEL_WIDTH+1)'(QUEUE_DEPTH);
  assign take        = in_valid && !in_stall;

  assign comp[0] = in_item.comp_x;
  assign comp[1] = in_item.comp_y;
  assign comp[2] = in_item.comp_z;
  assign comp[3] = in_item.comp_w;

  always_comb begin
    for (int i = 0; i < NUM_COMP; i++) begin
      mag_next[i] = comp[i][COMP_WIDTH-1] ? (~comp[i] + COMP_WIDTH'(1)) : comp[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      push    <= 1'b0;
    end else begin
      a_valid <= take;
      push    <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_COMP; i++) begin
      a_mag[i] <= mag_next[i];
      a_neg[i] <= comp[i][COMP_WIDTH-1];
      a_sq[i]  <= SQ_WIDTH'(mag_next[i]) * SQ_WIDTH'(mag_next[i]);
    end
    push_item.mag    <= a_mag;
    push_item.neg    <= a_neg;
    push_item.sum_sq <= (SUM_WIDTH'(a_sq[0]) + SUM_WIDTH'(a_sq[1]))
                      + (SUM_WIDTH'(a_sq[2]) + SUM_WIDTH'(a_sq[3]));
  end

endmodule
`default_nettype wire

// ===== hdl/vnorm_queue.sv =====
// Short queue that decouples the front part from the back part.
// Depends on vnorm_pkg.
`default_nettype none
module vnorm_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire vnorm_pkg::work_t push_item,
  input  wire logic             pop,
  output vnorm_pkg::work_t      pop_item,
  output vnorm_pkg::queue_status_t qstat
);
  import vnorm_pkg::*;

  work_t                  entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]    wr_ptr;
  logic [QUEUE_AW-1:0]    rd_ptr;
  logic [LEVEL_WIDTH-1:0] level;

  assign pop_item        = entries[rd_ptr];
  assign qstat.level     = level;
  assign qstat.not_empty = level != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QUEUE_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + QUEUE_AW'(1);
      if (push && !pop)      level <= level + LEVEL_WIDTH'(1);
      else if (pop && !push) level <= level - LEVEL_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

endmodule
`default_nettype wire

// ===== hdl/vnorm_back.sv =====
// Back part: pipelined square root, four pipelined dividers, output register.
// Depends on vnorm_pkg.
`default_nettype none
module vnorm_back (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire vnorm_pkg::queue_status_t qstat,
  input  wire vnorm_pkg::work_t         pop_item,
  output logic                          pop,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output vnorm_pkg::vec_out_t           out_item
);
  import vnorm_pkg::*;

  localparam int NS = COMP_WIDTH + 1;
  localparam int RW = COMP_WIDTH + 4;
  localparam int BW = 2 * NS;
  localparam int ND = OUT_FRAC_BITS + 1;
  localparam int RD = COMP_WIDTH + 1;
  localparam logic [OUT_FRAC_BITS:0] UNIT_ONE = (OUT_FRAC_BITS+1)'(1) << OUT_FRAC_BITS;
  localparam logic signed [UNIT_WIDTH-1:0] ONE_S = UNIT_WIDTH'(UNIT_ONE);

  logic adv;
  assign adv = !out_valid || !out_stall;
  assign pop = adv && qstat.not_empty;

  // Square root: one result bit per stage.
  logic [NS-1:0]                       s_v;
  logic [RW-1:0]                       s_rem  [NS];
  logic [LEN_WIDTH-1:0]                s_root [NS];
  logic [BW-1:0]                       s_bits [NS];
  logic [NUM_COMP-1:0][COMP_WIDTH-1:0] s_mag  [NS];
  logic [NUM_COMP-1:0]                 s_neg  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_sqrt
    logic                                v_i;
    logic [RW-1:0]                       rem_i, rem_sh, trial, rem_n;
    logic [LEN_WIDTH-1:0]                root_i, root_n;
    logic [BW-1:0]                       bits_i;
    logic [NUM_COMP-1:0][COMP_WIDTH-1:0] mag_i;
    logic [NUM_COMP-1:0]                 neg_i;

    if (s == 0) begin : g_first
      assign v_i    = pop;
      assign rem_i  = '0;
      assign root_i = '0;
      assign bits_i = BW'(pop_item.sum_sq);
      assign mag_i  = pop_item.mag;
      assign neg_i  = pop_item.neg;
    end else begin : g_next
      assign v_i    = s_v[s-1];
      assign rem_i  = s_rem[s-1];
      assign root_i = s_root[s-1];
      assign bits_i = s_bits[s-1];
      assign mag_i  = s_mag[s-1];
      assign neg_i  = s_neg[s-1];
    end

    always_comb begin
      rem_sh = {rem_i[RW-3:0], bits_i[BW-1 -: 2]};
      trial  = {1'b0, root_i, 2'b01};
      if (rem_sh >= trial) begin
        rem_n  = rem_sh - trial;
        root_n = {root_i[LEN_WIDTH-2:0], 1'b1};
      end else begin
        rem_n  = rem_sh;
        root_n = {root_i[LEN_WIDTH-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        s_v[s] <= 1'b0;
      end else if (adv) begin
        s_v[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        s_rem[s]  <= rem_n;
        s_root[s] <= root_n;
        s_bits[s] <= bits_i << 2;
        s_mag[s]  <= mag_i;
        s_neg[s]  <= neg_i;
      end
    end
  end

  // Division: four lanes, one quotient bit per stage. The magnitude never
  // exceeds the length, so only OUT_FRAC_BITS+1 quotient bits exist.
  logic [ND-1:0]                          d_v;
  logic [LEN_WIDTH-1:0]                   d_len [ND];
  logic [NUM_COMP-1:0][RD-1:0]            d_rem [ND];
  logic [NUM_COMP-1:0][OUT_FRAC_BITS:0]   d_q   [ND];
  logic [NUM_COMP-1:0]                    d_neg [ND];

  for (genvar d = 0; d < ND; d++) begin : g_div
    logic                                v_i;
    logic [LEN_WIDTH-1:0]                len_i;
    logic [NUM_COMP-1:0][RD-1:0]         rem_i, rem_n;
    logic [NUM_COMP-1:0][OUT_FRAC_BITS:0] q_i, q_n;
    logic [NUM_COMP-1:0]                 neg_i;
    logic [NUM_COMP-1:0]                 bit_in;
    logic [RD:0]                         rem_sh;

    if (d == 0) begin : g_first
      assign v_i   = s_v[NS-1];
      assign len_i = s_root[NS-1];
      assign neg_i = s_neg[NS-1];
      assign q_i   = '0;
      always_comb begin
        for (int i = 0; i < NUM_COMP; i++) begin
          rem_i[i]  = RD'(s_mag[NS-1][i] >> 1);
          bit_in[i] = s_mag[NS-1][i][0];
        end
      end
    end else begin : g_next
      assign v_i    = d_v[d-1];
      assign len_i  = d_len[d-1];
      assign neg_i  = d_neg[d-1];
      assign q_i    = d_q[d-1];
      assign rem_i  = d_rem[d-1];
      assign bit_in = '0;
    end

    always_comb begin
      rem_sh = '0;
      for (int i = 0; i < NUM_COMP; i++) begin
        rem_sh = {rem_i[i], bit_in[i]};
        if (rem_sh >= (RD+1)'(len_i)) begin
          rem_n[i] = RD'(rem_sh - (RD+1)'(len_i));
          q_n[i]   = {q_i[i][OUT_FRAC_BITS-1:0], 1'b1};
        end else begin
          rem_n[i] = RD'(rem_sh);
          q_n[i]   = {q_i[i][OUT_FRAC_BITS-1:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        d_v[d] <= 1'b0;
      end else if (adv) begin
        d_v[d] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d_len[d] <= len_i;
        d_rem[d] <= rem_n;
        d_q[d]   <= q_n;
        d_neg[d] <= neg_i;
      end
    end
  end

  // Output register: saturation, sign and the zero-vector case.
  logic [NUM_COMP-1:0][UNIT_WIDTH-1:0] unit_n;
  logic                                zero_n;

  assign zero_n = d_len[ND-1] == '0;

  always_comb begin
    for (int i = 0; i < NUM_COMP; i++) begin
      logic [OUT_FRAC_BITS:0] q_sat;
      q_sat = (d_q[ND-1][i] > UNIT_ONE) ? UNIT_ONE : d_q[ND-1][i];
      if (zero_n) begin
        unit_n[i] = '0;
      end else if (d_neg[ND-1][i]) begin
        unit_n[i] = ~UNIT_WIDTH'(q_sat) + UNIT_WIDTH'(1);
      end else begin
        unit_n[i] = UNIT_WIDTH'(q_sat);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d_v[ND-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item.unit_x     <= unit_n[0];
      out_item.unit_y     <= unit_n[1];
      out_item.unit_z     <= unit_n[2];
      out_item.unit_w     <= unit_n[3];
      out_item.vec_length <= d_len[ND-1];
      out_item.is_zero    <= zero_n;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> qstat.not_empty)
    else $error("queue popped while empty");

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.is_zero == (out_item.vec_length == '0)))
    else $error("zero flag disagrees with length");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.unit_x <= ONE_S && out_item.unit_x >= -ONE_S &&
                   out_item.unit_w <= ONE_S && out_item.unit_w >= -ONE_S))
    else $error("unit component out of range");

endmodule
`default_nettype wire

// ===== hdl/vec4_normalize.sv =====
// Top level of the four-component vector normalizer.
// Depends on vnorm_pkg, vnorm_front, vnorm_queue and vnorm_back.
//
// This block takes one signed Q7.8 vector per transfer and returns its
// Euclidean length (floor square root of the sum of squares, unsigned
// Q9.8) and each component divided by that length, truncated toward zero,
// in Q1.14 with 16384 standing for 1.0. An all-zero vector returns zeros
// with is_zero set. While the output is not stalled, the block sustains
// one transfer per clock in each direction. An item passes through 36
// register stages: the front magnitude-and-squaring register and its
// summing register, the queue entry, seventeen square-root stages (one
// root bit each), fifteen divider stages (one quotient bit each, four
// lanes in parallel) and the output register. A stall at the output
// freezes the back pipeline; the queue keeps the front side accepting
// until it fills.
`default_nettype none
module vec4_normalize (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire vnorm_pkg::vec_in_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output vnorm_pkg::vec_out_t      out_item
);
  import vnorm_pkg::*;

  queue_status_t qstat;
  logic          push;
  work_t         push_item;
  logic          pop;
  work_t         pop_item;

  // The front part classifies each vector and pushes it into the queue.
  vnorm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .qstat     (qstat),
    .push      (push),
    .push_item (push_item)
  );

  vnorm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .qstat     (qstat)
  );

  // The back part computes length and quotients and holds the result.
  vnorm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .pop_item  (pop_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
